### hw/rtl/conv3_pkg.sv
// ----------------------------------------------------------------------------
// conv3_pkg: shared types and constants
// Register map codes, field widths and the datapath struct for the 3x3 filter.
// ----------------------------------------------------------------------------
package conv3_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int CHANNELS_DEF  = 3;
    localparam int PIX_W         = 24;
    localparam int COL_W         = 10;
    localparam int ROW_W         = 12;
    localparam int ROW_CNT_W     = 13;
    localparam int ACC_W         = 20;
    localparam int MAX_HEIGHT    = 4096;

    localparam logic [2:0] REG_W_TOP    = 3'd0;
    localparam logic [2:0] REG_W_MID    = 3'd1;
    localparam logic [2:0] REG_W_BOT    = 3'd2;
    localparam logic [2:0] REG_DIVISOR  = 3'd3;
    localparam logic [2:0] REG_WIDTH    = 3'd4;
    localparam logic [2:0] REG_HEIGHT   = 3'd5;

    typedef struct packed {
        logic [23:0] w_top;
        logic [23:0] w_mid;
        logic [23:0] w_bot;
        logic [9:0]  divisor;
    } kernel_cfg_t;

    // Result sideband that follows a window through the arithmetic stages.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } pos_tag_t;

endpackage

### hw/rtl/conv3_line_buf.sv
// ----------------------------------------------------------------------------
// conv3_line_buf: row store and 3x3 window
// Holds the two previous rows in one synchronous memory and shifts the window.
// ----------------------------------------------------------------------------
module conv3_line_buf #(
    parameter int MAX_WIDTH = conv3_pkg::MAX_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
    input  logic                          wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
    input  logic [conv3_pkg::PIX_W-1:0]   cur,
    output logic [9*conv3_pkg::PIX_W-1:0] win
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int PW = conv3_pkg::PIX_W;

    logic [2*PW-1:0] mem [MAX_WIDTH];
    logic [2*PW-1:0] rd_data_reg;
    logic [AW:0]     fill_reg;
    logic            rd_valid_reg;
    logic [PW-1:0] win_reg [6];
    logic [PW-1:0] mid;
    logic [PW-1:0] top;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= {mid, cur};
        end
    end

    // Columns are written in order starting from zero, so the entries written
    // since reset always form one run from address zero. Anything at or above
    // the fill mark reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            rd_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            if (rd_en)
            begin
                rd_valid_reg <= ({1'b0, rd_addr} < fill_reg);
            end
            if (wr_en)
            begin
                if ({1'b0, wr_addr} >= fill_reg)
                begin
                    fill_reg <= {1'b0, wr_addr} + (AW+1)'(1);
                end
                win_reg[0] <= win_reg[1];
                win_reg[1] <= top;
                win_reg[2] <= win_reg[3];
                win_reg[3] <= mid;
                win_reg[4] <= win_reg[5];
                win_reg[5] <= cur;
            end
        end
    end

    assign mid = rd_valid_reg ? rd_data_reg[PW-1:0]    : '0;
    assign top = rd_valid_reg ? rd_data_reg[2*PW-1:PW] : '0;

    // Order: row-major, top row first, left column first.
    assign win = {cur, win_reg[5], win_reg[4], mid, win_reg[3], win_reg[2],
                  top, win_reg[1], win_reg[0]};
endmodule

### hw/rtl/conv3_mac.sv
// ----------------------------------------------------------------------------
// conv3_mac: per-channel weighted sum, divide and clamp
// Multiplies in one stage, sums in a second and divides serially.
// ----------------------------------------------------------------------------
module conv3_mac #(
    parameter int CHANNELS = conv3_pkg::CHANNELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [9*conv3_pkg::PIX_W-1:0] win,
    input  conv3_pkg::kernel_cfg_t        kcfg,
    output logic                          done,
    output logic [7:0]                    res [3]
);
    localparam int AW = conv3_pkg::ACC_W;
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUM  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_DONE = 3'd3;

    logic [2:0] state_reg, state_next;
    logic signed [16:0] prod_reg [3][9];
    logic [AW-1:0] mag_reg [3];
    logic neg_reg [3];
    logic [AW-1:0] quo_reg [3];
    logic [10:0] rem_reg [3];
    logic [4:0] bit_reg;
    logic [9:0] div_val;
    logic [71:0] wts;

    assign wts = {kcfg.w_bot, kcfg.w_mid, kcfg.w_top};
    assign div_val = (kcfg.divisor == '0) ? 10'd1 : kcfg.divisor;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_SUM;
            ST_SUM:  state_next = ST_DIV;
            ST_DIV:  if (bit_reg == '0) state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SUM)
            begin
                bit_reg <= 5'(AW - 1);
            end
            else if (state_reg == ST_DIV)
            begin
                bit_reg <= bit_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int k = 0; k < 9; k++)
                begin
                    prod_reg[c][k] <= $signed({1'b0, win[k*24 + c*8 +: 8]})
                                      * $signed(wts[k*8 +: 8]);
                end
            end
        end
        if (state_reg == ST_SUM)
        begin
            for (int c = 0; c < 3; c++)
            begin
                logic signed [AW-1:0] s;
                s = '0;
                for (int k = 0; k < 9; k++)
                begin
                    s = s + AW'(prod_reg[c][k]);
                end
                neg_reg[c] <= s[AW-1];
                mag_reg[c] <= s[AW-1] ? AW'(-s) : AW'(s);
                quo_reg[c] <= '0;
                rem_reg[c] <= '0;
            end
        end
        if (state_reg == ST_DIV)
        begin
            // Restoring division, one quotient bit per cycle.
            for (int c = 0; c < 3; c++)
            begin
                logic [10:0] r;
                r = {rem_reg[c][9:0], mag_reg[c][bit_reg]};
                if (r >= {1'b0, div_val})
                begin
                    rem_reg[c] <= r - {1'b0, div_val};
                    quo_reg[c] <= quo_reg[c] | (AW'(1) << bit_reg);
                end
                else
                begin
                    rem_reg[c] <= r;
                end
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (c >= CHANNELS || neg_reg[c] || quo_reg[c] == '0)
            begin
                res[c] = 8'd0;
            end
            else if (quo_reg[c] > AW'(255))
            begin
                res[c] = 8'd255;
            end
            else
            begin
                res[c] = quo_reg[c][7:0];
            end
        end
    end

    assign done = (state_reg == ST_DONE);
endmodule

### hw/rtl/convolution_3x3_div_clamp.sv
// ----------------------------------------------------------------------------
// convolution_3x3_div_clamp: 3x3 RGB filter with divide and clamp
// Raster pixels in, filtered interior pixels out, APB register port.
// ----------------------------------------------------------------------------
// A pixel word is accepted, its row store entry is read from a single-port
// style memory, the window is formed and multiplied, summed, and divided by
// a 20-step serial divider. No new word is accepted while one is in work; the
// next pixel is taken once the result word has moved to the output register,
// and a full output register stalls it. Border pixels produce no output word.
// Registers: 0 top weights, 1 middle weights, 2 bottom weights, 3 divisor,
// 4 width, 5 height. The row store starts at zero after reset without a
// clearing pass.
module convolution_3x3_div_clamp #(
    parameter int MAX_WIDTH = conv3_pkg::MAX_WIDTH_DEF,
    parameter int CHANNELS  = conv3_pkg::CHANNELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  pixel_red,
    input  logic [7:0]  pixel_green,
    input  logic [7:0]  pixel_blue,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [9:0]  centre_column,
    output logic [11:0] centre_row,
    output logic        last_of_frame
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = AW + 1;
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_MAC  = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [23:0] w_top_reg, w_mid_reg, w_bot_reg;
    logic [9:0]  div_reg;
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [2:0]  state_reg, state_next;
    logic [CW-1:0] col_reg;
    logic [12:0] row_reg;
    logic [23:0] pix_reg;
    logic        prod_reg;
    conv3_pkg::pos_tag_t tag_reg;
    logic [CW-1:0] w_eff;
    logic [12:0] h_eff;
    logic        interior;
    logic        mac_done;
    logic [7:0]  res [3];
    logic [9*24-1:0] win;
    conv3_pkg::kernel_cfg_t kcfg;
    logic        out_valid_reg;
    logic [7:0]  ored_reg, ogrn_reg, oblu_reg;
    conv3_pkg::pos_tag_t otag_reg;
    logic        wr_cfg;

    assign pready = 1'b1;
    assign wr_cfg = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_top_reg  <= '0;
            w_mid_reg  <= 24'd256;
            w_bot_reg  <= '0;
            div_reg    <= 10'd1;
            width_reg  <= 11'd1024;
            height_reg <= 13'd768;
        end
        else if (wr_cfg)
        begin
            unique case (paddr[4:2])
                conv3_pkg::REG_W_TOP:   w_top_reg  <= pwdata[23:0];
                conv3_pkg::REG_W_MID:   w_mid_reg  <= pwdata[23:0];
                conv3_pkg::REG_W_BOT:   w_bot_reg  <= pwdata[23:0];
                conv3_pkg::REG_DIVISOR: div_reg    <= pwdata[9:0];
                conv3_pkg::REG_WIDTH:   width_reg  <= pwdata[10:0];
                conv3_pkg::REG_HEIGHT:  height_reg <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            conv3_pkg::REG_W_TOP:   prdata = {8'd0, w_top_reg};
            conv3_pkg::REG_W_MID:   prdata = {8'd0, w_mid_reg};
            conv3_pkg::REG_W_BOT:   prdata = {8'd0, w_bot_reg};
            conv3_pkg::REG_DIVISOR: prdata = {22'd0, div_reg};
            conv3_pkg::REG_WIDTH:   prdata = {21'd0, width_reg};
            conv3_pkg::REG_HEIGHT:  prdata = {19'd0, height_reg};
            default:                prdata = '0;
        endcase
    end

    // Geometry saturated to the legal range.
    always_comb
    begin
        if (width_reg < 11'd3)
        begin
            w_eff = CW'(3);
        end
        else if ({21'd0, width_reg} > 32'(MAX_WIDTH))
        begin
            w_eff = CW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CW'(width_reg);
        end
        if (height_reg < 13'd3)
        begin
            h_eff = 13'd3;
        end
        else if (height_reg > 13'(conv3_pkg::MAX_HEIGHT))
        begin
            h_eff = 13'(conv3_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    assign interior = (row_reg >= 13'd2) && (col_reg >= CW'(2))
                      && (row_reg < h_eff) && (col_reg < w_eff);
    assign kcfg = '{w_top: w_top_reg, w_mid: w_mid_reg, w_bot: w_bot_reg,
                    divisor: div_reg};

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_READ;
            ST_READ: state_next = prod_reg ? ST_MAC : ST_IDLE;
            ST_MAC:  state_next = ST_WAIT;
            ST_WAIT: if (mac_done) state_next = ST_OUT;
            ST_OUT:  if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            prod_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && in_valid)
            begin
                prod_reg <= interior;
            end
            if (state_reg == ST_READ)
            begin
                if (col_reg + CW'(1) >= w_eff)
                begin
                    col_reg <= '0;
                    row_reg <= (row_reg + 13'd1 >= h_eff) ? 13'd0 : row_reg + 13'd1;
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            if (state_reg == ST_OUT && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            pix_reg     <= {pixel_blue, pixel_green, pixel_red};
            tag_reg.col <= 10'(col_reg - CW'(1));
            tag_reg.row <= 12'(row_reg - 13'd1);
            tag_reg.last <= (row_reg == h_eff - 13'd1) && (col_reg == w_eff - CW'(1));
        end
        if (state_reg == ST_OUT && (!out_valid_reg || out_ready))
        begin
            ored_reg <= res[0];
            ogrn_reg <= res[1];
            oblu_reg <= res[2];
            otag_reg <= tag_reg;
        end
    end

    conv3_line_buf #(.MAX_WIDTH(MAX_WIDTH)) u_line_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (state_reg == ST_IDLE && in_valid),
        .rd_addr (col_reg[AW-1:0]),
        .wr_en   (state_reg == ST_READ),
        .wr_addr (col_reg[AW-1:0]),
        .cur     (pix_reg),
        .win     (win)
    );

    // The window is captured by the multiplier stage in the read cycle.
    conv3_mac #(.CHANNELS(CHANNELS)) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_READ && prod_reg),
        .win   (win),
        .kcfg  (kcfg),
        .done  (mac_done),
        .res   (res)
    );

    assign out_valid     = out_valid_reg;
    assign out_red       = ored_reg;
    assign out_green     = ogrn_reg;
    assign out_blue      = oblu_reg;
    assign centre_column = otag_reg.col;
    assign centre_row    = otag_reg.row;
    assign last_of_frame = otag_reg.last;
endmodule

### hw/rtl/conv3_checker.sv
// ----------------------------------------------------------------------------
// conv3_checker: port-level checks
// Watches the top level's handshakes and result words.
// ----------------------------------------------------------------------------
module conv3_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_red,
    input logic       pready
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_red))
        else $error("result word dropped while stalled");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word taken while busy");
endmodule

bind convolution_3x3_div_clamp conv3_checker u_conv3_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .pready    (pready)
);
